// ===== rtl/ptrmx_pkg.sv =====
package ptrmx_pkg;

  // default sizing
  localparam int VALUE_BITS_DEF      = 19;
  localparam int MAX_VERSIONS_DEF    = 1024;
  localparam int NODE_POOL_DEPTH_DEF = 32768;

  // command codes
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

endpackage

// ===== rtl/persistent_trie_range_max_xor.sv =====
// Versioned binary trie with range max-XOR queries. An item is taken at a clock edge with
// start high and busy low; every item yields exactly one result, shown on out_* for a single
// cycle with out_strobe high, and the receiver cannot stall it. Clear, the unused command and
// any rejected command (full store, bad or empty range) answer in the next cycle with busy
// staying low. An append holds busy through one root-table read, then one node write per trie
// level while the next old node is read. A query holds busy through a root-table read and a
// root-node read; then per level the node memory is read once for the counts of the preferred
// children of both versions and, when those counts match, a second time for the other
// children, each read being registered. No clearing pass is needed after reset: node 0 and
// root 0 read as zero by address.
module persistent_trie_range_max_xor #(
  parameter int VALUE_BITS      = ptrmx_pkg::VALUE_BITS_DEF,
  parameter int MAX_VERSIONS    = ptrmx_pkg::MAX_VERSIONS_DEF,
  parameter int NODE_POOL_DEPTH = ptrmx_pkg::NODE_POOL_DEPTH_DEF,
  localparam int VER_W          = $clog2(MAX_VERSIONS + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_cmd,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic [VER_W-1:0]      in_left_version,
  input  logic [VER_W-1:0]      in_right_version,
  output logic                  out_strobe,
  output logic [VALUE_BITS-1:0] out_max_xor,
  output logic [1:0]            out_status
);

  localparam int NODE_W = $clog2(NODE_POOL_DEPTH);
  localparam int CNT_W  = $clog2(MAX_VERSIONS + 1);
  localparam int LVL_W  = $clog2(VALUE_BITS + 1);
  localparam int NEED   = VALUE_BITS + 1;
  localparam int SUM_W  = NODE_W + 7;

  typedef struct packed {
    logic [NODE_W-1:0] kid0;
    logic [NODE_W-1:0] kid1;
    logic [CNT_W-1:0]  cnt;
  } node_t;

  typedef enum logic [2:0] {
    S_IDLE, S_A_NODE, S_A_WR, S_Q_NODE, S_Q_LOAD, S_Q_ISSUE, S_Q_CMP, S_Q_OTHER
  } state_t;

  function automatic logic [NODE_W-1:0] kid_of(input node_t n, input logic b);
    kid_of = b ? n.kid1 : n.kid0;
  endfunction

  // memories
  node_t             node_mem [NODE_POOL_DEPTH];
  logic [NODE_W-1:0] root_mem [MAX_VERSIONS+1];

  node_t             node_qa_r, node_qb_r, nqa, nqb;
  logic              nza_r, nzb_r;
  logic [NODE_W-1:0] root_qa_r, root_qb_r, rqa, rqb;
  logic              rza_r, rzb_r;

  logic              node_we;
  logic [NODE_W-1:0] node_wa, node_ra_a, node_ra_b;
  node_t             node_wd;
  logic              root_we;
  logic [VER_W-1:0]  root_wa, root_ra_a, root_ra_b;
  logic [NODE_W-1:0] root_wd;

  // registers
  state_t                 state_r, state_nxt;
  logic [NODE_W-1:0]      nf_r, nf_nxt;
  logic [VER_W-1:0]       vc_r, vc_nxt;
  logic [VALUE_BITS-1:0]  value_r, value_nxt;
  logic [VALUE_BITS-1:0]  sh_r, sh_nxt;
  logic [VALUE_BITS-1:0]  found_r, found_nxt;
  logic [LVL_W-1:0]       lvl_r, lvl_nxt;
  logic [NODE_W-1:0]      cur_r, cur_nxt;
  node_t                  xn_r, xn_nxt, yn_r, yn_nxt;
  logic                   out_strobe_r, out_strobe_nxt;
  logic [VALUE_BITS-1:0]  out_max_xor_r, out_max_xor_nxt;
  logic [1:0]             out_status_r, out_status_nxt;

  logic accept, full, want, take, bit_b;
  logic [SUM_W-1:0] nf_need;

  // node pool: one write, two registered reads
  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_wa] <= node_wd;
    end
    node_qa_r <= node_mem[node_ra_a];
    node_qb_r <= node_mem[node_ra_b];
    nza_r     <= (node_ra_a == '0);
    nzb_r     <= (node_ra_b == '0);
  end

  // version root table: one write, two registered reads
  always_ff @(posedge clk) begin
    if (root_we) begin
      root_mem[root_wa] <= root_wd;
    end
    root_qa_r <= root_mem[root_ra_a];
    root_qb_r <= root_mem[root_ra_b];
    rza_r     <= (root_ra_a == '0);
    rzb_r     <= (root_ra_b == '0);
  end

  // null node and root 0 read as zero
  assign nqa = nza_r ? '0 : node_qa_r;
  assign nqb = nzb_r ? '0 : node_qb_r;
  assign rqa = rza_r ? '0 : root_qa_r;
  assign rqb = rzb_r ? '0 : root_qb_r;

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign nf_need = SUM_W'(nf_r) + SUM_W'(NEED);
  assign full    = (vc_r >= VER_W'(MAX_VERSIONS)) ||
                   (nf_need > SUM_W'(NODE_POOL_DEPTH - 1));
  assign want    = ~sh_r[VALUE_BITS-1];
  assign bit_b   = sh_r[VALUE_BITS-1];

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    nf_nxt          = nf_r;
    vc_nxt          = vc_r;
    value_nxt       = value_r;
    sh_nxt          = sh_r;
    found_nxt       = found_r;
    lvl_nxt         = lvl_r;
    cur_nxt         = cur_r;
    xn_nxt          = xn_r;
    yn_nxt          = yn_r;
    out_strobe_nxt  = 1'b0;
    out_max_xor_nxt = out_max_xor_r;
    out_status_nxt  = out_status_r;
    node_we         = 1'b0;
    node_wa         = cur_r;
    node_wd         = nqa;
    node_ra_a       = '0;
    node_ra_b       = '0;
    root_we         = 1'b0;
    root_wa         = VER_W'(vc_r + 1'b1);
    root_wd         = NODE_W'(nf_r + 1'b1);
    root_ra_a       = '0;
    root_ra_b       = '0;
    take            = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_max_xor_nxt = '0;
          out_status_nxt  = ptrmx_pkg::ST_OK;
          case (in_cmd)
            ptrmx_pkg::CMD_CLEAR: begin
              nf_nxt         = '0;
              vc_nxt         = '0;
              out_strobe_nxt = 1'b1;
            end
            ptrmx_pkg::CMD_APPEND: begin
              if (full) begin
                out_status_nxt = ptrmx_pkg::ST_FULL;
                out_strobe_nxt = 1'b1;
              end else begin
                value_nxt = in_value;
                root_ra_a = vc_r;
                state_nxt = S_A_NODE;
              end
            end
            ptrmx_pkg::CMD_QUERY: begin
              if (in_left_version > in_right_version || in_right_version > vc_r) begin
                out_status_nxt = ptrmx_pkg::ST_BAD;
                out_strobe_nxt = 1'b1;
              end else if (in_left_version == in_right_version) begin
                out_status_nxt = ptrmx_pkg::ST_EMPTY;
                out_strobe_nxt = 1'b1;
              end else begin
                root_ra_a = in_right_version;
                root_ra_b = in_left_version;
                value_nxt = in_value;
                sh_nxt    = in_value;
                found_nxt = '0;
                lvl_nxt   = LVL_W'(VALUE_BITS);
                state_nxt = S_Q_NODE;
              end
            end
            default: begin
              out_strobe_nxt = 1'b1;
            end
          endcase
        end
      end

      // new root gets the next free node, old root node is fetched
      S_A_NODE: begin
        node_ra_a = rqa;
        root_we   = 1'b1;
        cur_nxt   = NODE_W'(nf_r + 1'b1);
        sh_nxt    = value_r;
        lvl_nxt   = LVL_W'(VALUE_BITS);
        state_nxt = S_A_WR;
      end

      // copy old node with count + 1; above the leaf, link fresh child and fetch next old node
      S_A_WR: begin
        node_we     = 1'b1;
        node_wd.cnt = CNT_W'(nqa.cnt + 1'b1);
        if (lvl_r != '0) begin
          if (bit_b) begin
            node_wd.kid1 = NODE_W'(cur_r + 1'b1);
          end else begin
            node_wd.kid0 = NODE_W'(cur_r + 1'b1);
          end
          node_ra_a = kid_of(nqa, bit_b);
          cur_nxt   = NODE_W'(cur_r + 1'b1);
          sh_nxt    = sh_r << 1;
          lvl_nxt   = LVL_W'(lvl_r - 1'b1);
        end else begin
          nf_nxt          = cur_r;
          vc_nxt          = VER_W'(vc_r + 1'b1);
          out_max_xor_nxt = '0;
          out_status_nxt  = ptrmx_pkg::ST_OK;
          out_strobe_nxt  = 1'b1;
          state_nxt       = S_IDLE;
        end
      end

      S_Q_NODE: begin
        node_ra_a = rqa;
        node_ra_b = rqb;
        state_nxt = S_Q_LOAD;
      end

      S_Q_LOAD: begin
        xn_nxt    = nqa;
        yn_nxt    = nqb;
        state_nxt = S_Q_ISSUE;
      end

      // fetch preferred children of both versions
      S_Q_ISSUE: begin
        node_ra_a = kid_of(xn_r, want);
        node_ra_b = kid_of(yn_r, want);
        state_nxt = S_Q_CMP;
      end

      S_Q_CMP: begin
        if (nqa.cnt != nqb.cnt) begin
          take = want;
        end else begin
          node_ra_a = kid_of(xn_r, ~want);
          node_ra_b = kid_of(yn_r, ~want);
          state_nxt = S_Q_OTHER;
        end
      end

      S_Q_OTHER: begin
        take = ~want;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // one query level resolved
    if ((state_r == S_Q_CMP && nqa.cnt != nqb.cnt) || state_r == S_Q_OTHER) begin
      xn_nxt    = nqa;
      yn_nxt    = nqb;
      found_nxt = (found_r << 1) | VALUE_BITS'(take);
      sh_nxt    = sh_r << 1;
      lvl_nxt   = LVL_W'(lvl_r - 1'b1);
      if (lvl_r == LVL_W'(1)) begin
        out_max_xor_nxt = found_nxt ^ value_r;
        out_status_nxt  = ptrmx_pkg::ST_OK;
        out_strobe_nxt  = 1'b1;
        state_nxt       = S_IDLE;
      end else begin
        state_nxt = S_Q_ISSUE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      nf_r         <= '0;
      vc_r         <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      nf_r          <= nf_nxt;
      vc_r          <= vc_nxt;
      value_r       <= value_nxt;
      sh_r          <= sh_nxt;
      found_r       <= found_nxt;
      lvl_r         <= lvl_nxt;
      cur_r         <= cur_nxt;
      xn_r          <= xn_nxt;
      yn_r          <= yn_nxt;
      out_strobe_r  <= out_strobe_nxt;
      out_max_xor_r <= out_max_xor_nxt;
      out_status_r  <= out_status_nxt;
    end
  end

  assign out_strobe  = out_strobe_r;
  assign out_max_xor = out_max_xor_r;
  assign out_status  = out_status_r;

  // results only come out once the sequencer is back in idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while busy");

  // clear answers at once with ok and zero
  a_clear_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd == ptrmx_pkg::CMD_CLEAR) |=>
      (out_strobe && out_status == ptrmx_pkg::ST_OK && out_max_xor == '0 && vc_r == '0))
    else $error("clear result wrong");

  // a finished append adds exactly one version
  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_A_WR && lvl_r == '0) |=> (vc_r == VER_W'($past(vc_r) + 1'b1)))
    else $error("version count not advanced");

  // empty range answers in the next cycle
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd == ptrmx_pkg::CMD_QUERY && in_left_version == in_right_version &&
     in_right_version <= vc_r) |=> (out_strobe && out_status == ptrmx_pkg::ST_EMPTY))
    else $error("empty range result wrong");

endmodule

// ===== test/trie_answer_monitor.sv =====
`timescale 1ns / 1ps

// Watches both channels of the trie block, keeps its own copy of the versioned
// trie and checks every result item against the answer predicted for its command.
module trie_answer_monitor #(
  parameter int VALUE_BITS      = ptrmx_pkg::VALUE_BITS_DEF,
  parameter int MAX_VERSIONS    = ptrmx_pkg::MAX_VERSIONS_DEF,
  parameter int NODE_POOL_DEPTH = ptrmx_pkg::NODE_POOL_DEPTH_DEF,
  localparam int VER_W          = $clog2(MAX_VERSIONS + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic [1:0]            in_cmd,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic [VER_W-1:0]      in_left_version,
  input  logic [VER_W-1:0]      in_right_version,
  input  logic                  out_strobe,
  input  logic [VALUE_BITS-1:0] out_max_xor,
  input  logic [1:0]            out_status,
  output int                    queued,
  output int                    mismatches
);

  typedef struct packed {
    logic [VALUE_BITS-1:0] max_xor;
    logic [1:0]            status;
  } trie_answer_t;

  // shadow trie: root per version, two children and a count per node
  int unsigned root_of  [0:MAX_VERSIONS];
  int unsigned node_kid [0:1][0:NODE_POOL_DEPTH-1];
  int unsigned node_cnt [0:NODE_POOL_DEPTH-1];
  int unsigned top_node;
  int unsigned ver_cnt;

  trie_answer_t answer_q [$];

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $time, what);
    mismatches++;
  endtask

  // new node takes the children of the old one, count one higher
  function automatic void dup_node(int unsigned dst, int unsigned src);
    node_kid[0][dst] = node_kid[0][src];
    node_kid[1][dst] = node_kid[1][src];
    node_cnt[dst]    = node_cnt[src] + 1;
  endfunction

  // applies one command to the shadow trie and returns its result item
  function automatic trie_answer_t apply_command(logic [1:0] cmd, logic [VALUE_BITS-1:0] val,
                                                 logic [VER_W-1:0] lo, logic [VER_W-1:0] hi);
    trie_answer_t ans;
    int unsigned  cur, old, fresh, x, y, diff;
    logic         b, want, take;
    logic [VALUE_BITS-1:0] path;
    ans.max_xor = '0;
    ans.status  = ptrmx_pkg::ST_OK;
    case (cmd)
      ptrmx_pkg::CMD_CLEAR: begin
        top_node       = 0;
        ver_cnt        = 0;
        root_of[0]     = 0;
        node_kid[0][0] = 0;
        node_kid[1][0] = 0;
        node_cnt[0]    = 0;
      end
      ptrmx_pkg::CMD_APPEND: begin
        if (ver_cnt >= MAX_VERSIONS || top_node + VALUE_BITS + 1 > NODE_POOL_DEPTH - 1) begin
          ans.status = ptrmx_pkg::ST_FULL;
        end else begin
          old = root_of[ver_cnt];
          top_node++;
          cur = top_node;
          root_of[ver_cnt + 1] = cur;
          // copy the previous path, one fresh node per level
          for (int j = VALUE_BITS - 1; j >= 0; j--) begin
            b = val[j];
            dup_node(cur, old);
            top_node++;
            fresh = top_node;
            node_kid[b][cur] = fresh;
            cur = fresh;
            old = node_kid[b][old];
          end
          dup_node(cur, old);
          ver_cnt++;
        end
      end
      ptrmx_pkg::CMD_QUERY: begin
        if (lo > hi || hi > ver_cnt) begin
          ans.status = ptrmx_pkg::ST_BAD;
        end else if (lo == hi) begin
          ans.status = ptrmx_pkg::ST_EMPTY;
        end else begin
          x    = root_of[hi];
          y    = root_of[lo];
          path = '0;
          // prefer the opposite bit wherever the range holds an element there
          for (int j = VALUE_BITS - 1; j >= 0; j--) begin
            want = ~val[j];
            diff = node_cnt[node_kid[want][x]] - node_cnt[node_kid[want][y]];
            take = (diff != 0) ? want : ~want;
            x = node_kid[take][x];
            y = node_kid[take][y];
            path[j] = take;
          end
          ans.max_xor = path ^ val;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  // results are checked before the item taken at the same edge is queued
  always @(posedge clk) begin
    trie_answer_t expd;
    if (!rst_n) begin
      answer_q.delete();
      void'(apply_command(ptrmx_pkg::CMD_CLEAR, '0, '0, '0));
    end else begin
      if (out_strobe === 1'b1) begin
        if (answer_q.size() == 0) begin
          report_mismatch($sformatf("result with no item pending: max_xor %0h status %0d",
                                    out_max_xor, out_status));
        end else begin
          expd = answer_q.pop_front();
          if (out_max_xor !== expd.max_xor)
            report_mismatch($sformatf("max_xor %0h, expected %0h", out_max_xor, expd.max_xor));
          if (out_status !== expd.status)
            report_mismatch($sformatf("status %0d, expected %0d", out_status, expd.status));
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        answer_q.push_back(apply_command(in_cmd, in_value, in_left_version, in_right_version));
    end
    queued <= answer_q.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int VALUE_BITS      = ptrmx_pkg::VALUE_BITS_DEF;
  localparam int MAX_VERSIONS    = ptrmx_pkg::MAX_VERSIONS_DEF;
  localparam int NODE_POOL_DEPTH = ptrmx_pkg::NODE_POOL_DEPTH_DEF;
  localparam int VER_W           = $clog2(MAX_VERSIONS + 1);
  localparam int VER_TOP         = (1 << VER_W) - 1;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int STALL_LIMIT     = 1000;
  localparam int DRAIN_CYCLES    = 3 * VALUE_BITS + 12;

  logic                  clk              = 1'b0;
  logic                  rst_n            = 1'b0;
  logic                  start            = 1'b0;
  logic [1:0]            in_cmd           = ptrmx_pkg::CMD_CLEAR;
  logic [VALUE_BITS-1:0] in_value         = '0;
  logic [VER_W-1:0]      in_left_version  = '0;
  logic [VER_W-1:0]      in_right_version = '0;
  logic                  busy;
  logic                  out_strobe;
  logic [VALUE_BITS-1:0] out_max_xor;
  logic [1:0]            out_status;

  int fail_count;
  int pending;
  int versions;
  int sent;
  int stall_cycles;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  persistent_trie_range_max_xor dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_value         (in_value),
    .in_left_version  (in_left_version),
    .in_right_version (in_right_version),
    .out_strobe       (out_strobe),
    .out_max_xor      (out_max_xor),
    .out_status       (out_status)
  );

  trie_answer_monitor answer_mon (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_value         (in_value),
    .in_left_version  (in_left_version),
    .in_right_version (in_right_version),
    .out_strobe       (out_strobe),
    .out_max_xor      (out_max_xor),
    .out_status       (out_status),
    .queued           (pending),
    .mismatches       (fail_count)
  );

  // watchdog: cycles in which neither an item nor a result moves
  always @(posedge clk) begin
    if (!rst_n || (start === 1'b1 && busy === 1'b0) || out_strobe === 1'b1) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // one item; random gaps except in a steady stretch of the run
  task automatic send_item(input logic [1:0] c, input logic [VALUE_BITS-1:0] v,
                           input int lo, input int hi);
    if (sent < 150 || sent >= 330) begin
      while ($urandom_range(99) < 24) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start            <= 1'b1;
    in_cmd           <= c;
    in_value         <= v;
    in_left_version  <= lo[VER_W-1:0];
    in_right_version <= hi[VER_W-1:0];
    do @(posedge clk); while (busy !== 1'b0);
    sent++;
    if (c == ptrmx_pkg::CMD_CLEAR)
      versions = 0;
    else if (c == ptrmx_pkg::CMD_APPEND && versions < MAX_VERSIONS)
      versions++;
  endtask

  // mix of extremes, small values and clustered values so paths share prefixes
  function automatic logic [VALUE_BITS-1:0] pick_value();
    logic [VALUE_BITS-1:0] v;
    v = VALUE_BITS'($urandom);
    case ($urandom_range(7))
      0: v = '0;
      1: v = '1;
      2: v = VALUE_BITS'($urandom_range(15));
      3: v = {{(VALUE_BITS - 4){1'b1}}, v[3:0]};
      default: ;
    endcase
    return v;
  endfunction

  // query within the stored versions, nonempty whenever possible
  task automatic send_good_query();
    int lo, hi;
    if (versions == 0) begin
      send_item(ptrmx_pkg::CMD_QUERY, pick_value(), 0, 0);
    end else begin
      lo = $urandom_range(versions - 1, 0);
      hi = $urandom_range(versions, lo + 1);
      send_item(ptrmx_pkg::CMD_QUERY, pick_value(), lo, hi);
    end
  endtask

  // unused command and the two kinds of bad range
  task automatic send_noise();
    int lo, hi;
    case ($urandom_range(2))
      0: send_item(CMD_UNUSED, VALUE_BITS'($urandom), $urandom_range(VER_TOP),
                   $urandom_range(VER_TOP));
      1: begin
        hi = $urandom_range(VER_TOP, versions + 1);
        lo = $urandom_range(hi, 0);
        send_item(ptrmx_pkg::CMD_QUERY, pick_value(), lo, hi);
      end
      default: begin
        lo = $urandom_range(VER_TOP, 1);
        hi = $urandom_range(lo - 1, 0);
        send_item(ptrmx_pkg::CMD_QUERY, pick_value(), lo, hi);
      end
    endcase
  endtask

  initial begin
    int len;
    int r;
    versions = 0;
    sent     = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty store, extremes, every command, every status but full
    send_item(ptrmx_pkg::CMD_QUERY, '0, 0, 0);
    send_item(ptrmx_pkg::CMD_QUERY, '1, 0, 1);
    send_item(CMD_UNUSED, '1, VER_TOP, VER_TOP);
    send_item(ptrmx_pkg::CMD_APPEND, '0, 0, 0);
    send_item(ptrmx_pkg::CMD_APPEND, '1, 0, 0);
    send_item(ptrmx_pkg::CMD_APPEND, VALUE_BITS'(19'h2AAAA), 0, 0);
    send_item(ptrmx_pkg::CMD_APPEND, VALUE_BITS'(19'h55555), 0, 0);
    send_item(ptrmx_pkg::CMD_QUERY, '0, 0, 4);
    send_item(ptrmx_pkg::CMD_QUERY, '1, 0, 4);
    send_item(ptrmx_pkg::CMD_QUERY, VALUE_BITS'(19'h12345), 1, 3);
    send_item(ptrmx_pkg::CMD_QUERY, '1, 2, 2);
    send_item(ptrmx_pkg::CMD_QUERY, '0, 3, 2);
    send_item(ptrmx_pkg::CMD_QUERY, '0, 0, 5);
    send_item(ptrmx_pkg::CMD_QUERY, '0, VER_TOP, VER_TOP);
    send_item(ptrmx_pkg::CMD_QUERY, '1, MAX_VERSIONS, VER_TOP);
    send_item(ptrmx_pkg::CMD_APPEND, '1, 0, 0);
    send_item(ptrmx_pkg::CMD_QUERY, '0, 4, 5);
    send_item(ptrmx_pkg::CMD_CLEAR, '1, VER_TOP, VER_TOP);
    send_item(ptrmx_pkg::CMD_QUERY, '0, 0, 1);
    send_item(ptrmx_pkg::CMD_APPEND, VALUE_BITS'(1), 0, 0);
    send_item(ptrmx_pkg::CMD_QUERY, VALUE_BITS'(1), 0, 1);
    send_item(CMD_UNUSED, VALUE_BITS'($urandom), $urandom_range(VER_TOP),
              $urandom_range(VER_TOP));

    // random sessions of appends and queries, each usually after a clear
    while (sent < 60) begin
      if ($urandom_range(3) != 0)
        send_item(ptrmx_pkg::CMD_CLEAR, VALUE_BITS'($urandom), $urandom_range(VER_TOP),
                  $urandom_range(VER_TOP));
      len = $urandom_range(60, 4);
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(99);
        if (r < 45)
          send_item(ptrmx_pkg::CMD_APPEND, pick_value(), $urandom_range(VER_TOP),
                    $urandom_range(VER_TOP));
        else if (r < 90)
          send_good_query();
        else
          send_noise();
      end
    end

    // fill the version table, then push against the full store
    send_item(ptrmx_pkg::CMD_CLEAR, '0, 0, 0);
    while (versions < MAX_VERSIONS) begin
      r = $urandom_range(99);
      if (r < 95)
        send_item(ptrmx_pkg::CMD_APPEND, pick_value(), $urandom_range(VER_TOP),
                  $urandom_range(VER_TOP));
      else if (r < 98)
        send_good_query();
      else
        send_noise();
    end
    repeat (3) send_item(ptrmx_pkg::CMD_APPEND, pick_value(), 0, 0);
    send_item(ptrmx_pkg::CMD_QUERY, '0, 0, MAX_VERSIONS);
    send_item(ptrmx_pkg::CMD_QUERY, '1, 0, MAX_VERSIONS);
    send_item(ptrmx_pkg::CMD_QUERY, pick_value(), MAX_VERSIONS - 1, MAX_VERSIONS);
    send_item(ptrmx_pkg::CMD_QUERY, pick_value(), MAX_VERSIONS, MAX_VERSIONS);
    send_item(ptrmx_pkg::CMD_QUERY, pick_value(), 0, MAX_VERSIONS + 1);
    send_item(ptrmx_pkg::CMD_QUERY, pick_value(), MAX_VERSIONS, VER_TOP);
    repeat (20) send_good_query();

    // store works again after a clear
    send_item(ptrmx_pkg::CMD_CLEAR, '0, 0, 0);
    send_item(ptrmx_pkg::CMD_APPEND, pick_value(), 0, 0);
    send_item(ptrmx_pkg::CMD_APPEND, pick_value(), 0, 0);
    send_good_query();
    send_good_query();

    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    // every item must have had its result by now
    if (fail_count == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
